// ===== design/sprite_row_compositor_assert.svh =====
// ----------------------------------------------------------------------------
// Sprite row compositor assertion macros
// Shorthand for the concurrent checks placed at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SPRITE_ROW_COMPOSITOR_ASSERT_SVH
`define SPRITE_ROW_COMPOSITOR_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define SRC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define SRC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/src_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite row compositor package
// Operation codes, field widths and the decoded request type.
// ----------------------------------------------------------------------------
package src_pkg;

   // Request operations carried in req_tuser
   typedef enum logic [1:0] {
      OP_PIXEL_WRITE   = 2'd0,
      OP_PALETTE_WRITE = 2'd1,
      OP_KEY_WRITE     = 2'd2,
      OP_DRAW          = 2'd3
   } op_type;

   localparam int SPRITE_W  = 4;
   localparam int FRAME_W   = 3;
   localparam int ROW_W     = 4;
   localparam int BCOL_W    = 3;
   localparam int SLOT_W    = 4;
   localparam int XPOS_W    = 11;
   localparam int DATA_W    = 16;
   localparam int PIX_X_W   = 10;
   localparam int COLOR_W   = 16;
   localparam int NIBBLE_W  = 4;
   localparam int KEY_W     = 5;
   localparam int BYTE_W    = 8;
   localparam int COL_W     = 4;
   localparam int PAL_DEPTH = 16;

   // Packed widths of the stream payloads
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 32;

   // Decoded request payload
   typedef struct packed {
      logic [SPRITE_W-1:0]      sprite;
      logic [FRAME_W-1:0]       frame;
      logic [ROW_W-1:0]         row;
      logic [BCOL_W-1:0]        byte_column;
      logic [SLOT_W-1:0]        palette_slot;
      logic signed [XPOS_W-1:0] x_position;
      logic [DATA_W-1:0]        data;
   } req_fields_type;

endpackage

// ===== design/src_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module src_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/sprite_row_compositor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite row compositor
// Stores 4-bit sprite pixels, per-frame key colors and a 16-entry palette,
// and turns a draw item into sixteen line-buffer pixel items.
// ----------------------------------------------------------------------------
//  channel | dir | handshake             | payload
//  req     | in  | req_tvalid/req_tready | tuser op, tdata fields
//  rsp     | out | rsp_tvalid/rsp_tready | tuser write_enable, tdata, tlast
//
//  A write item is taken in idle, leaves the block idle and yields no result.
//  A draw item steps through accept, one pixel RAM fetch, then sixteen
//  results through the shared x adder and line compare; the pixel RAM
//  read port fetches the next byte while the odd column of a pair is sent.
//  rsp_tready low holds the sequencer; the result register keeps its item.
//  Reset (synchronous) returns to idle and drops the pending result; the
//  stores keep their contents and are undefined until written.
// ----------------------------------------------------------------------------
module sprite_row_compositor #(
   parameter int LINE_WIDTH   = 320,
   parameter int SPRITE_COUNT = 16,
   parameter int FRAME_COUNT  = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [1:0] op
   input  logic [1:0]  req_tuser,
   // [3:0] sprite, [6:4] frame, [10:7] row, [13:11] byte_column,
   // [17:14] palette_slot, [28:18] x_position, [44:29] data, [47:45] zero
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] write_enable
   output logic        rsp_tuser,
   // [9:0] pixel_x, [25:10] pixel_color, [31:26] zero
   output logic [31:0] rsp_tdata,
   output logic        rsp_tlast
);

   localparam int PIX_DEPTH = SPRITE_COUNT * 1024;
   localparam int PIX_AW    = $clog2(PIX_DEPTH);
   localparam int KEY_DEPTH = SPRITE_COUNT * 8;
   localparam int KEY_AW    = $clog2(KEY_DEPTH);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_FETCH = 2'd1;
   localparam logic [1:0] S_PIX   = 2'd2;

   src_pkg::req_fields_type req_f;
   src_pkg::op_type         req_op;
   logic                    req_fire;
   logic                    req_ok;

   logic [1:0] state_ff, state_in;
   logic [src_pkg::COL_W-1:0] col_ff, col_in;

   // Latched draw item
   logic [src_pkg::SPRITE_W-1:0]      spr_ff;
   logic [src_pkg::FRAME_W-1:0]       frm_ff;
   logic [src_pkg::ROW_W-1:0]         row_ff;
   logic signed [src_pkg::XPOS_W-1:0] x_ff;
   logic                              ok_ff;

   logic [src_pkg::COLOR_W-1:0] palette_ff [src_pkg::PAL_DEPTH];

   // Result register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_we_ff;
   logic [src_pkg::PIX_X_W-1:0] rsp_x_ff;
   logic [src_pkg::COLOR_W-1:0] rsp_color_ff;
   logic                        rsp_last_ff;

   logic                         emit;
   logic                         pix_wr_en;
   logic [PIX_AW-1:0]            pix_wr_addr;
   logic                         pix_rd_en;
   logic [PIX_AW-1:0]            pix_rd_addr;
   logic [src_pkg::BYTE_W-1:0]   pix_rd_data;
   logic [src_pkg::BCOL_W-1:0]   byte_sel;
   logic                         key_wr_en;
   logic [KEY_AW-1:0]            key_wr_addr;
   logic                         key_rd_en;
   logic [KEY_AW-1:0]            key_rd_addr;
   logic [src_pkg::KEY_W-1:0]    key_rd_data;

   logic signed [src_pkg::XPOS_W:0] x_sum;
   logic                            online;
   logic [src_pkg::NIBBLE_W-1:0]    nibble;
   logic                            pix_we;

   // Unpack the request payload
   assign req_op             = src_pkg::op_type'(req_tuser);
   assign req_f.sprite       = req_tdata[3:0];
   assign req_f.frame        = req_tdata[6:4];
   assign req_f.row          = req_tdata[10:7];
   assign req_f.byte_column  = req_tdata[13:11];
   assign req_f.palette_slot = req_tdata[17:14];
   assign req_f.x_position   = req_tdata[28:18];
   assign req_f.data         = req_tdata[44:29];

   // Accept only in idle and out of reset
   assign req_tready = (state_ff == S_IDLE) && !reset;
   assign req_fire   = req_tvalid && req_tready;
   assign req_ok     = ({1'b0, req_f.sprite} < (src_pkg::SPRITE_W+1)'(SPRITE_COUNT))
                    && ({1'b0, req_f.frame} < (src_pkg::FRAME_W+1)'(FRAME_COUNT));

   // Store writes straight from the accepted item
   assign pix_wr_en   = req_fire && (req_op == src_pkg::OP_PIXEL_WRITE) && req_ok;
   assign pix_wr_addr = PIX_AW'({req_f.sprite, req_f.frame, req_f.row, req_f.byte_column});
   assign key_wr_en   = req_fire && (req_op == src_pkg::OP_KEY_WRITE) && req_ok;
   assign key_wr_addr = KEY_AW'({req_f.sprite, req_f.frame});

   always_ff @(posedge clock) begin
      if (req_fire && (req_op == src_pkg::OP_PALETTE_WRITE)) begin
         palette_ff[req_f.palette_slot] <= req_f.data;
      end
   end

   // Result register advances when empty or taken
   assign emit = (state_ff == S_PIX) && (!rsp_valid_ff || rsp_tready);

   // Fetch byte 0, then the next byte while the odd column goes out
   assign byte_sel    = col_ff[3:1] + {2'b00, col_ff[0]};
   assign pix_rd_en   = (state_ff == S_FETCH) || (emit && col_ff[0]);
   assign pix_rd_addr = PIX_AW'({spr_ff, frm_ff, row_ff, byte_sel});
   assign key_rd_en   = (state_ff == S_FETCH);
   assign key_rd_addr = KEY_AW'({spr_ff, frm_ff});

   src_ram #(
      .WIDTH (src_pkg::BYTE_W),
      .DEPTH (PIX_DEPTH)
   ) u_pix_ram (
      .clock   (clock),
      .wr_en   (pix_wr_en),
      .wr_addr (pix_wr_addr),
      .wr_data (req_f.data[src_pkg::BYTE_W-1:0]),
      .rd_en   (pix_rd_en),
      .rd_addr (pix_rd_addr),
      .rd_data (pix_rd_data)
   );

   src_ram #(
      .WIDTH (src_pkg::KEY_W),
      .DEPTH (KEY_DEPTH)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (key_wr_addr),
      .wr_data (req_f.data[src_pkg::KEY_W-1:0]),
      .rd_en   (key_rd_en),
      .rd_addr (key_rd_addr),
      .rd_data (key_rd_data)
   );

   // Shared column unit: screen x, line clip and key compare
   assign x_sum  = {x_ff[src_pkg::XPOS_W-1], x_ff}
                 + (src_pkg::XPOS_W+1)'(col_ff);
   assign online = !x_sum[src_pkg::XPOS_W]
                && (x_sum < (src_pkg::XPOS_W+1)'(LINE_WIDTH));
   assign nibble = col_ff[0] ? pix_rd_data[7:4] : pix_rd_data[3:0];
   assign pix_we = ok_ff && online && ({1'b0, nibble} != key_rd_data);

   // Sequencer
   always_comb begin
      state_in = state_ff;
      col_in   = col_ff;
      unique case (state_ff)
         S_IDLE: begin
            col_in = '0;
            if (req_fire && (req_op == src_pkg::OP_DRAW)) begin
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            state_in = S_PIX;
         end
         S_PIX: begin
            if (emit) begin
               col_in = col_ff + 1'b1;
               if (col_ff == {src_pkg::COL_W{1'b1}}) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         col_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Latch the draw item
   always_ff @(posedge clock) begin
      if (req_fire && (req_op == src_pkg::OP_DRAW)) begin
         spr_ff <= req_f.sprite;
         frm_ff <= req_f.frame;
         row_ff <= req_f.row;
         x_ff   <= req_f.x_position;
         ok_ff  <= req_ok;
      end
   end

   // Load the result register
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_we_ff    <= pix_we;
         rsp_x_ff     <= online ? x_sum[src_pkg::PIX_X_W-1:0] : '0;
         rsp_color_ff <= pix_we ? palette_ff[nibble] : '0;
         rsp_last_ff  <= (col_ff == {src_pkg::COL_W{1'b1}});
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_we_ff;
   assign rsp_tdata  = {6'd0, rsp_color_ff, rsp_x_ff};
   assign rsp_tlast  = rsp_last_ff;

`include "sprite_row_compositor_assert.svh"

   // A written pixel lies on the line
   `SRC_ASSERT_NOW(a_we_on_line, clock, reset, rsp_valid_ff && rsp_we_ff,
      rsp_x_ff < src_pkg::PIX_X_W'(LINE_WIDTH), "written pixel off the line")

   // A skipped pixel carries no color
   `SRC_ASSERT_NOW(a_skip_no_color, clock, reset, rsp_valid_ff && !rsp_we_ff,
      rsp_color_ff == '0, "skipped pixel has a color")

   // A draw item makes the block busy in the next cycle
   `SRC_ASSERT_NEXT(a_draw_busy, clock, reset, req_fire && (req_op == src_pkg::OP_DRAW),
      !req_tready && (col_ff == '0), "draw item not started")

endmodule

// ===== tb/tb_sprite_row_compositor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite row compositor testbench
// Fills the pixel, key and palette stores, then draws rows at edge and random
// x positions. A scoreboard models the stores and checks all sixteen pixel
// items of each draw, in order. Random idling runs on both streams, and one
// long receiver hold-off backs the block up into its request port.
// ----------------------------------------------------------------------------
module tb_sprite_row_compositor;
   import src_pkg::*;

   localparam int LINE_WIDTH   = 320;
   localparam int SPRITE_COUNT = 16;
   localparam int FRAME_COUNT  = 8;
   localparam int PERIOD       = 20;
   localparam int RESET_CYCLES = 12;
   localparam int ITEM_TARGET  = 430;
   localparam int LONG_HOLD    = 300;
   localparam int HOLD_AT_ITEM = 150;
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int PRINT_CAP    = 30;

   // One expected line-buffer pixel
   typedef struct packed {
      logic                 we;
      logic [PIX_X_W-1:0]   px;
      logic [COLOR_W-1:0]   color;
      logic                 last;
   } line_pixel_type;

   // --------------------------------------------------------------------------
   // Store model and pixel checker
   // --------------------------------------------------------------------------
   class line_pixel_scoreboard;
      logic [BYTE_W-1:0]  sprite_bytes [16384];
      logic [KEY_W-1:0]   frame_keys [128];
      logic [COLOR_W-1:0] palette_rgb [PAL_DEPTH];
      line_pixel_type     pending_pixels [$];
      int                 mismatches;

      task report(input string msg);
         if (mismatches < PRINT_CAP)
            $display("[%0t] mismatch: %s", $realtime, msg);
         mismatches++;
      endtask

      function int pending();
         return pending_pixels.size();
      endfunction

      // Update the stores, or queue the sixteen pixels of a draw
      function void note_request(op_type op, req_fields_type f);
         logic [6:0]        frame_index;
         logic [BYTE_W-1:0] pixel_byte;
         logic [3:0]        nibble;
         int                x;
         bit                in_range;
         bit                on_line;
         line_pixel_type    p;
         frame_index = {f.sprite, f.frame};
         in_range = (f.sprite < SPRITE_COUNT) && (f.frame < FRAME_COUNT);
         case (op)
            OP_PIXEL_WRITE: begin
               if (in_range)
                  sprite_bytes[{frame_index, f.row, f.byte_column}] = f.data[7:0];
            end
            OP_PALETTE_WRITE: begin
               palette_rgb[f.palette_slot] = f.data;
            end
            OP_KEY_WRITE: begin
               if (in_range)
                  frame_keys[frame_index] = f.data[KEY_W-1:0];
            end
            OP_DRAW: begin
               for (int c = 0; c < 16; c++) begin
                  pixel_byte = sprite_bytes[{frame_index, f.row, 3'(c / 2)}];
                  nibble = (c % 2 == 1) ? pixel_byte[7:4] : pixel_byte[3:0];
                  x = $signed(f.x_position) + c;
                  on_line = (x >= 0) && (x < LINE_WIDTH);
                  p.we = in_range && on_line && ({1'b0, nibble} != frame_keys[frame_index]);
                  p.px = on_line ? x[PIX_X_W-1:0] : '0;
                  p.color = p.we ? palette_rgb[nibble] : '0;
                  p.last = (c == 15);
                  pending_pixels.push_back(p);
               end
            end
            default: ;
         endcase
      endfunction

      // Compare one accepted pixel item with the oldest expectation
      task check_result(input logic we, input logic [PIX_X_W-1:0] px,
                        input logic [COLOR_W-1:0] color, input logic last);
         line_pixel_type e;
         if (pending_pixels.size() == 0) begin
            report($sformatf("unexpected pixel item x=%0d we=%b", px, we));
         end else begin
            e = pending_pixels.pop_front();
            if (we !== e.we)
               report($sformatf("write_enable %b, expected %b (x=%0d)", we, e.we, e.px));
            if (px !== e.px)
               report($sformatf("pixel_x %0d, expected %0d", px, e.px));
            if (color !== e.color)
               report($sformatf("pixel_color %h, expected %h (x=%0d)", color, e.color, e.px));
            if (last !== e.last)
               report($sformatf("last %b, expected %b (x=%0d)", last, e.last, e.px));
         end
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [1:0]  req_tuser;
   logic [47:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic        rsp_tuser;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;

   line_pixel_scoreboard board;
   int                   items_sent;
   int                   cycle_count;
   bit                   req_bursty;
   bit                   rsp_bursty;
   bit                   hold_request;
   bit                   row_ready [2048];
   logic [10:0]          ready_rows [$];

   sprite_row_compositor #(
      .LINE_WIDTH   (LINE_WIDTH),
      .SPRITE_COUNT (SPRITE_COUNT),
      .FRAME_COUNT  (FRAME_COUNT)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial clock = 1'b0;
   always #(PERIOD / 2) clock = ~clock;

   // Stop a hung run
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Random x, biased toward both line edges
   function automatic logic signed [XPOS_W-1:0] random_x();
      case ($urandom_range(0, 3))
         0:       return XPOS_W'(int'($urandom_range(0, 31)) - 16);
         1:       return XPOS_W'(LINE_WIDTH - 20 + int'($urandom_range(0, 23)));
         default: return XPOS_W'(int'($urandom_range(0, 1039)) - 16);
      endcase
   endfunction

   // Mostly keys that can match a pixel, some that never match
   function automatic logic [KEY_W-1:0] random_key();
      if ($urandom_range(0, 3) == 0)
         return KEY_W'($urandom_range(16, 31));
      return KEY_W'($urandom_range(0, 15));
   endfunction

   function automatic req_fields_type random_fields();
      req_fields_type f;
      f.sprite       = SPRITE_W'($urandom_range(0, 15));
      f.frame        = FRAME_W'($urandom_range(0, 7));
      f.row          = ROW_W'($urandom_range(0, 15));
      f.byte_column  = BCOL_W'($urandom_range(0, 7));
      f.palette_slot = SLOT_W'($urandom_range(0, 15));
      f.x_position   = random_x();
      f.data         = DATA_W'($urandom_range(0, 65535));
      return f;
   endfunction

   // Offer one request item after a random gap; note it once accepted
   task automatic send_item(input op_type op, input req_fields_type f);
      int gap;
      gap = req_bursty ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {3'b000, f.data, f.x_position, f.palette_slot, f.byte_column,
                     f.row, f.frame, f.sprite};
      do @(posedge clock); while (!req_tready);
      board.note_request(op, f);
      items_sent++;
   endtask

   task automatic write_key(input logic [10:0] row_id, input logic [KEY_W-1:0] key);
      req_fields_type f;
      f = random_fields();
      f.sprite = row_id[10:7];
      f.frame  = row_id[6:4];
      f.data[KEY_W-1:0] = key;
      send_item(OP_KEY_WRITE, f);
   endtask

   // Key plus all eight bytes of one row, after which the row may be drawn
   task automatic write_row(input logic [10:0] row_id, input logic [KEY_W-1:0] key,
                            input logic [7:0] row_bytes [8]);
      req_fields_type f;
      write_key(row_id, key);
      for (int b = 0; b < 8; b++) begin
         f = random_fields();
         f.sprite      = row_id[10:7];
         f.frame       = row_id[6:4];
         f.row         = row_id[3:0];
         f.byte_column = BCOL_W'(b);
         f.data[7:0]   = row_bytes[b];
         send_item(OP_PIXEL_WRITE, f);
      end
      if (!row_ready[row_id])
         ready_rows.push_back(row_id);
      row_ready[row_id] = 1'b1;
   endtask

   task automatic draw_row(input logic [10:0] row_id, input logic signed [XPOS_W-1:0] x);
      req_fields_type f;
      f = random_fields();
      f.sprite     = row_id[10:7];
      f.frame      = row_id[6:4];
      f.row        = row_id[3:0];
      f.x_position = x;
      send_item(OP_DRAW, f);
   endtask

   // --------------------------------------------------------------------------
   // Result side: random stalls, one long hold-off, check every item
   // --------------------------------------------------------------------------
   initial begin : result_side
      int stall;
      int taken;
      stall = 0;
      taken = 0;
      rsp_bursty = 1'b0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (rsp_tvalid && rsp_tready) begin
               board.check_result(rsp_tuser, rsp_tdata[PIX_X_W-1:0],
                                  rsp_tdata[PIX_X_W +: COLOR_W], rsp_tlast);
               taken++;
               if (taken % 48 == 0)
                  rsp_bursty = ($urandom_range(0, 2) == 0);
               stall = rsp_bursty ? 0 : $urandom_range(0, 4);
            end else if (stall > 0) begin
               stall--;
            end
            if (hold_request) begin
               hold_request = 1'b0;
               stall = LONG_HOLD;
            end
         end
         rsp_tready <= (stall == 0) && !reset;
      end
   end

   // --------------------------------------------------------------------------
   // Request side: directed items, then random row sequences and noise
   // --------------------------------------------------------------------------
   initial begin : stimulus
      req_fields_type f;
      logic [7:0]     row_bytes [8];
      logic [10:0]    row_id;
      int             pick;
      int             next_switch;
      bit             hold_done;
      board = new();
      items_sent   = 0;
      req_bursty   = 1'b0;
      hold_request = 1'b0;
      hold_done    = 1'b0;
      next_switch  = 40;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser  <= OP_PIXEL_WRITE;
      req_tdata  <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Whole palette, with all-zero and all-one colors at the ends
      for (int s = 0; s < PAL_DEPTH; s++) begin
         f = random_fields();
         f.palette_slot = SLOT_W'(s);
         if (s == 0)
            f.data = 16'h0000;
         else if (s == PAL_DEPTH - 1)
            f.data = 16'hFFFF;
         send_item(OP_PALETTE_WRITE, f);
      end

      // Last sprite, frame and row, key zero, nibbles at both extremes
      row_id = {4'd15, 3'd7, 4'd15};
      row_bytes = '{8'h00, 8'hF0, 8'h0F, 8'hFF, 8'h10, 8'h32, 8'h54, 8'hE7};
      write_row(row_id, 5'd0, row_bytes);
      // Fully off the left, partly off, flush left, flush right, partly off
      // the right, last on-line pixel, far past the line
      draw_row(row_id, -11'sd16);
      draw_row(row_id, -11'sd8);
      draw_row(row_id, 11'sd0);
      draw_row(row_id, 11'(LINE_WIDTH - 16));
      draw_row(row_id, 11'(LINE_WIDTH - 8));
      draw_row(row_id, 11'(LINE_WIDTH - 1));
      draw_row(row_id, 11'sd1023);
      // Key of sixteen never matches
      write_key(row_id, 5'd16);
      draw_row(row_id, -11'sd3);

      // First sprite, frame and row with the largest key
      row_id = '0;
      foreach (row_bytes[b]) row_bytes[b] = 8'($urandom_range(0, 255));
      row_bytes[0] = 8'h00;
      write_row(row_id, 5'd31, row_bytes);
      draw_row(row_id, 11'sd150);

      // Random part
      while (items_sent < ITEM_TARGET) begin
         if (items_sent >= next_switch) begin
            req_bursty = ($urandom_range(0, 2) == 0);
            next_switch += 40;
         end
         if (!hold_done && items_sent >= HOLD_AT_ITEM) begin
            hold_request = 1'b1;
            hold_done    = 1'b1;
         end
         pick = $urandom_range(0, 99);
         f = random_fields();
         if (pick < 45) begin
            // Fill one row, then draw it a few times
            row_id = {f.sprite, f.frame, f.row};
            foreach (row_bytes[b]) row_bytes[b] = 8'($urandom_range(0, 255));
            write_row(row_id, random_key(), row_bytes);
            repeat ($urandom_range(1, 3)) draw_row(row_id, random_x());
         end else if (pick < 70 && ready_rows.size() > 0) begin
            draw_row(ready_rows[$urandom_range(0, ready_rows.size() - 1)], random_x());
         end else if (pick < 82) begin
            send_item(OP_PALETTE_WRITE, f);
         end else if (pick < 90 && ready_rows.size() > 0) begin
            write_key(ready_rows[$urandom_range(0, ready_rows.size() - 1)], random_key());
         end else begin
            // Stray byte write, drawn only if its row is already complete
            send_item(OP_PIXEL_WRITE, f);
         end
      end
      req_tvalid <= 1'b0;

      // Drain the results, then watch for strays
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+design
design/src_pkg.sv
design/src_ram.sv
design/sprite_row_compositor.sv
tb/tb_sprite_row_compositor.sv
